FILE: sv/motor_duty_ramp_limiter_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the duty ramp limiter
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MOTOR_DUTY_RAMP_LIMITER_TOP_ASSERT_SVH
`define MOTOR_DUTY_RAMP_LIMITER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MDRL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MDRL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/mdrl_pkg.sv
// ----------------------------------------------------------------------------
// Duty ramp limiter package
// Widths, register indexes, reset values and shared structs.
// ----------------------------------------------------------------------------
package mdrl_pkg;

  localparam int unsigned TIME_WIDTH  = 48;
  localparam int unsigned DUTY_WIDTH  = 8;
  localparam int unsigned IVAL_WIDTH  = 24;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_DUTY_CAP   = 2'd0,
    REG_ACCEL_STEP       = 2'd1,
    REG_RAMP_INTERVAL_US = 2'd2
  } cfg_reg_e;

  localparam logic [DUTY_WIDTH-1:0] START_CAP_RESET = 8'd128;
  localparam logic [DUTY_WIDTH-1:0] ACCEL_RESET     = 8'd16;
  localparam logic [IVAL_WIDTH-1:0] INTERVAL_RESET  = 24'd50000;

  typedef struct packed {
    logic [DUTY_WIDTH-1:0] start_duty_cap;
    logic [DUTY_WIDTH-1:0] accel_step;
    logic [IVAL_WIDTH-1:0] ramp_interval_us;
  } cfg_t;

  typedef struct packed {
    logic [DUTY_WIDTH-1:0] requested_duty;
    logic                  direction;
    logic [TIME_WIDTH-1:0] time_now_us;
  } cmd_t;

  typedef struct packed {
    logic                  drive_a;
    logic                  drive_b;
    logic [DUTY_WIDTH-1:0] duty;
    logic                  reversal_brake;
  } res_t;

endpackage

FILE: sv/motor_duty_ramp_limiter_top.sv
// ----------------------------------------------------------------------------
// Motor duty ramp limiter
// Slew-rate limits the PWM duty of one H-bridge motor, with reversal braking.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the input channel (in_valid_i / in_ready_o) with a
//   requested duty, a rotation sense and a microsecond timestamp. Each
//   command yields exactly one result on the output channel
//   (out_valid_o / out_ready_i): the two bridge drive levels, the limited
//   duty and a flag telling whether the command forced a reversal stop.
//   The input transfer loads the input register; the ramp rule then runs in
//   a single combinational pass and lands in the result register when that
//   register is empty or its result is being taken, so a stall can hold the
//   command in the input register. Throughput is one command per cycle while
//   the receiver does not stall; the motor state is updated in the same
//   cycle as the result register loads, so the next command sees it.
//   When the receiver stalls, the result register holds, the input register
//   fills, and in_ready_o drops until the result is taken.
//   Reset clears both pipeline stages, returns the configuration registers
//   to their defaults and puts the motor at standstill with unknown sense.
//   Configuration writes (cfg_we_i) take effect at once and should be made
//   while no command is in flight.
// ----------------------------------------------------------------------------
module motor_duty_ramp_limiter_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mdrl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mdrl_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [mdrl_pkg::DUTY_WIDTH-1:0]    requested_duty_i,
  input  logic                               direction_i,
  input  logic [mdrl_pkg::TIME_WIDTH-1:0]    time_now_us_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               drive_a_o,
  output logic                               drive_b_o,
  output logic [mdrl_pkg::DUTY_WIDTH-1:0]    duty_o,
  output logic                               reversal_brake_o
);
  import mdrl_pkg::*;

  cfg_t cfg;
  cmd_t cmd_q;
  res_t res, res_q;
  logic cmd_valid_q;
  logic res_valid_q;
  logic advance;

  mdrl_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The held command moves into the result register whenever that register
  // is empty or its current result is being transferred out this cycle.
  assign advance    = cmd_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !cmd_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      cmd_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q.requested_duty <= requested_duty_i;
      cmd_q.direction      <= direction_i;
      cmd_q.time_now_us    <= time_now_us_i;
    end
  end

  // The core commits its motor state exactly when a result is loaded.
  mdrl_ramp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .cmd_i  (cmd_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = res_valid_q;
  assign drive_a_o        = res_q.drive_a;
  assign drive_b_o        = res_q.drive_b;
  assign duty_o           = res_q.duty;
  assign reversal_brake_o = res_q.reversal_brake;

endmodule

FILE: sv/mdrl_cfg_regs.sv
// ----------------------------------------------------------------------------
// Duty ramp limiter configuration registers
// Holds the start cap, acceleration step and ramp interval.
// ----------------------------------------------------------------------------
module mdrl_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mdrl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mdrl_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output mdrl_pkg::cfg_t                      cfg_o
);
  import mdrl_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_START_DUTY_CAP:   cfg_d.start_duty_cap   = cfg_wdata_i[DUTY_WIDTH-1:0];
        REG_ACCEL_STEP:       cfg_d.accel_step       = cfg_wdata_i[DUTY_WIDTH-1:0];
        REG_RAMP_INTERVAL_US: cfg_d.ramp_interval_us = cfg_wdata_i[IVAL_WIDTH-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_duty_cap   <= START_CAP_RESET;
      cfg_q.accel_step       <= ACCEL_RESET;
      cfg_q.ramp_interval_us <= INTERVAL_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/mdrl_ramp_core.sv
// ----------------------------------------------------------------------------
// Duty ramp limiter core
// Motor state registers and the single-pass brake and ramp rule.
// ----------------------------------------------------------------------------
`include "motor_duty_ramp_limiter_top_assert.svh"

module mdrl_ramp_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  mdrl_pkg::cmd_t  cmd_i,
  input  mdrl_pkg::cfg_t  cfg_i,
  output mdrl_pkg::res_t  res_o
);
  import mdrl_pkg::*;

  logic [DUTY_WIDTH-1:0] speed_q, speed_d;
  logic                  dir_known_q;
  logic                  dir_now_q;
  logic [TIME_WIDTH-1:0] last_q, last_d;

  logic                  brake;
  logic [DUTY_WIDTH-1:0] speed_eff;
  logic [TIME_WIDTH-1:0] last_eff;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [DUTY_WIDTH:0]   sum;
  logic [DUTY_WIDTH-1:0] duty;

  always_comb begin
    brake     = dir_known_q && (cmd_i.direction != dir_now_q);
    speed_eff = brake ? '0 : speed_q;
    last_eff  = brake ? cmd_i.time_now_us : last_q;
    elapsed   = cmd_i.time_now_us - last_eff;
    sum       = {1'b0, speed_eff} + {1'b0, cfg_i.accel_step};
    duty      = cmd_i.requested_duty;
    last_d    = last_eff;
    if (cmd_i.requested_duty > speed_eff) begin
      duty = speed_eff;
      if (speed_eff == '0) begin
        duty   = (cmd_i.requested_duty < cfg_i.start_duty_cap) ?
                 cmd_i.requested_duty : cfg_i.start_duty_cap;
        last_d = cmd_i.time_now_us;
      end else if (elapsed >= {{(TIME_WIDTH-IVAL_WIDTH){1'b0}}, cfg_i.ramp_interval_us}) begin
        last_d = cmd_i.time_now_us;
        duty   = (sum >= {1'b0, cmd_i.requested_duty}) ?
                 cmd_i.requested_duty : sum[DUTY_WIDTH-1:0];
      end
    end
    speed_d = duty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q     <= '0;
      dir_known_q <= 1'b0;
      dir_now_q   <= 1'b0;
      last_q      <= '0;
    end else if (step_i) begin
      speed_q     <= speed_d;
      dir_known_q <= 1'b1;
      dir_now_q   <= cmd_i.direction;
      last_q      <= last_d;
    end
  end

  always_comb begin
    res_o.drive_a        = cmd_i.direction;
    res_o.drive_b        = ~cmd_i.direction;
    res_o.duty           = duty;
    res_o.reversal_brake = brake;
  end

  // The applied duty never exceeds the request.
  `MDRL_ASSERT_SAME(a_duty_le_req, step_i, duty <= cmd_i.requested_duty)
  // A brake restarts from standstill, so the start cap bounds the duty.
  `MDRL_ASSERT_SAME(a_brake_capped, step_i && brake,
                    duty <= cfg_i.start_duty_cap || duty == cmd_i.requested_duty)
  // While running, one command raises the duty by at most one step.
  `MDRL_ASSERT_SAME(a_rise_limited, step_i && !brake && speed_q != '0 && duty > speed_q,
                    {1'b0, duty} <= sum)
  // Any command makes the direction known from then on.
  `MDRL_ASSERT_NEXT(a_dir_known, step_i, dir_known_q && dir_now_q == $past(cmd_i.direction))

endmodule
